### hdl/aca_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the autotuned channel allocator
package aca_pkg;

    localparam int MAX_CH  = 64;
    localparam int CH_W    = $clog2(MAX_CH);
    localparam int SPR_W   = $clog2(MAX_CH + 1);
    localparam int CNT_W   = 8;
    localparam int LOAD_W  = 16;
    localparam int CFG_IW  = 3;

    localparam logic [SPR_W-1:0]  MAX_SPR  = SPR_W'(MAX_CH);
    localparam logic [LOAD_W-1:0] LOAD_MAX = '1;

    localparam logic [7:0] RST_MAX_PENDING = 8'd4;
    localparam logic [7:0] RST_SPREAD_REQ  = 8'hFC;
    localparam logic [6:0] RST_MID_TUNE    = 7'd8;
    localparam logic [6:0] RST_ZIP_TUNE    = 7'd32;
    localparam logic [6:0] RST_MAX_TUNE    = 7'd16;
    localparam logic [6:0] RST_MIN_TUNE    = 7'd4;

    typedef enum logic [CFG_IW-1:0] {
        REG_MAX_PENDING = 3'd0,
        REG_SPREAD      = 3'd1,
        REG_MID_TUNE    = 3'd2,
        REG_ZIP_TUNE    = 3'd3,
        REG_MAX_TUNE    = 3'd4,
        REG_MIN_TUNE    = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        OP_GET = 2'd0,
        OP_RET = 2'd1,
        OP_RSV = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CHECK,
        S_RMW,
        S_DONE
    } t_state;

    typedef struct packed {
        logic             rd_en;
        logic [CH_W-1:0]  rd_addr;
        logic             wr_en;
        logic [CH_W-1:0]  wr_addr;
        logic [CNT_W-1:0] wr_data;
    } t_mem_req;

    function automatic logic [LOAD_W-1:0] sat_add(input logic [LOAD_W-1:0] a,
                                                  input logic [LOAD_W-1:0] b);
        logic [LOAD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[LOAD_W] ? LOAD_MAX : s[LOAD_W-1:0];
    endfunction

endpackage

### hdl/aca_count_mem.sv
`timescale 1ns / 1ps
// pending count memory with per-entry valid bits and a registered read
module aca_count_mem (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  aca_pkg::t_mem_req         i_req,
    output logic [aca_pkg::CNT_W-1:0] o_count
);

    logic [aca_pkg::CNT_W-1:0] r_mem [aca_pkg::MAX_CH];
    logic [aca_pkg::MAX_CH-1:0] r_vld;
    logic [aca_pkg::CNT_W-1:0] r_rd;
    logic                      r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd <= r_mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_vld[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_vld[i_req.rd_addr];
            end
        end
    end

    // entries never written read as zero
    assign o_count = r_rd_vld ? r_rd : '0;

endmodule

### hdl/autotuned_channel_allocator.sv
`timescale 1ns / 1ps
// top level of the autotuned channel allocator
//
// Input channel (i_in_valid / o_in_ready) carries an opcode and a channel:
// get hands out the next channel round-robin, return lowers a channel's
// pending count, reserve takes a slot on the named channel. Every
// transaction yields one result on the output channel (o_out_valid /
// i_out_ready) with status, granted channel, current spread, partition
// start and the auto tuning flag.
// Return and reserve go through a memory read, a read-modify-write and an
// output load. A get starts with a setup step, then reads and compares the
// pending count of each channel it examines, takes a further step per wrap
// or tuning step, and ends with the output load.
// One transaction is worked at a time; the next is accepted as soon as the
// previous result sits in the output register, and a stalled receiver holds
// that register, so at most one finished result plus one in work.
// The config channel (i_cfg_valid / o_cfg_ready) is always ready and is to be
// written only while the block is idle; the block itself does not enforce
// this. A spread write takes effect at once.
// Reset is synchronous: counts read zero, spread is 4 with tuning on.
module autotuned_channel_allocator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_opcode,
    input  logic [aca_pkg::CH_W-1:0]        i_channel,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_status,
    output logic [aca_pkg::CH_W-1:0]        o_granted_channel,
    output logic [aca_pkg::SPR_W-1:0]       o_spread_now,
    output logic [aca_pkg::CH_W-1:0]        o_partition_start,
    output logic                            o_auto_tuning,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [aca_pkg::CFG_IW-1:0]      i_cfg_index,
    input  logic [7:0]                      i_cfg_data
);

    aca_pkg::t_state r_state, n_state;

    logic [7:0]                r_max_pending, n_max_pending;
    logic [6:0]                r_mid, n_mid, r_zip, n_zip, r_mxt, n_mxt, r_mint, n_mint;
    logic [aca_pkg::SPR_W-1:0] r_spread, n_spread, r_next, n_next, r_idx, n_idx;
    logic [aca_pkg::SPR_W-1:0] r_end, n_end;
    logic [aca_pkg::CH_W-1:0]  r_nps, n_nps, r_gch, n_gch;
    logic [aca_pkg::LOAD_W-1:0] r_old, n_old, r_new, n_new;
    logic                      r_tune, n_tune, r_merge, n_merge, r_status, n_status;
    logic [1:0]                r_op, n_op;
    logic                      r_ov, n_ov;
    logic                      r_o_status, n_o_status, r_o_tune, n_o_tune;
    logic [aca_pkg::CH_W-1:0]  r_o_gch, n_o_gch, r_o_nps, n_o_nps;
    logic [aca_pkg::SPR_W-1:0] r_o_spr, n_o_spr;

    aca_pkg::t_mem_req         mem_req;
    logic [aca_pkg::CNT_W-1:0] count;

    aca_count_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_count (count)
    );

    // tuning growth target
    logic [7:0] tune_n;
    always_comb begin
        if ({1'b0, r_spread} < {1'b0, r_mid}) begin
            tune_n = {r_spread, 1'b0};
        end else if ({1'b0, r_spread} < {1'b0, r_zip}) begin
            tune_n = {1'b0, r_spread} + {1'b0, r_mid};
        end else begin
            tune_n = {1'b0, r_spread} + {1'b0, r_mxt};
        end
    end

    logic [aca_pkg::LOAD_W-1:0] old_dec;
    logic [aca_pkg::LOAD_W:0]   new_lim;
    logic signed [7:0]          cfg_s;
    logic [7:0]                 cfg_mag;
    logic [aca_pkg::SPR_W-1:0]  cfg_ns;
    logic                       cfg_tune;
    logic [aca_pkg::SPR_W-1:0]  head;

    assign old_dec = (r_old != '0) ? r_old - 1'b1 : r_old;
    assign new_lim = {1'b0, r_new} + {2'b0, r_new[aca_pkg::LOAD_W-1:1]};
    assign cfg_s   = signed'(i_cfg_data);
    assign head    = aca_pkg::MAX_SPR - r_spread;

    always_comb begin
        n_state = r_state;
        n_max_pending = r_max_pending;
        n_mid = r_mid; n_zip = r_zip; n_mxt = r_mxt; n_mint = r_mint;
        n_spread = r_spread; n_next = r_next; n_idx = r_idx; n_end = r_end;
        n_nps = r_nps; n_gch = r_gch; n_old = r_old; n_new = r_new;
        n_tune = r_tune; n_merge = r_merge; n_status = r_status; n_op = r_op;
        n_ov = r_ov; n_o_status = r_o_status; n_o_tune = r_o_tune;
        n_o_gch = r_o_gch; n_o_nps = r_o_nps; n_o_spr = r_o_spr;
        mem_req = '0;
        cfg_mag = '0; cfg_ns = '0; cfg_tune = 1'b0;

        if (r_ov && i_out_ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            aca_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_op = i_opcode;
                    n_idx = {1'b0, i_channel};
                    case (i_opcode)
                        aca_pkg::OP_GET: begin
                            n_idx = r_next;
                            n_end = r_spread;
                            n_state = aca_pkg::S_SCAN;
                        end
                        aca_pkg::OP_RET, aca_pkg::OP_RSV: begin
                            mem_req.rd_en = 1'b1;
                            mem_req.rd_addr = i_channel;
                            n_state = aca_pkg::S_RMW;
                        end
                        default: begin
                            n_status = 1'b1;
                            n_gch = '0;
                            n_state = aca_pkg::S_DONE;
                        end
                    endcase
                end
            end
            aca_pkg::S_SCAN: begin
                if (r_idx < r_end && r_idx < aca_pkg::MAX_SPR) begin
                    mem_req.rd_en = 1'b1;
                    mem_req.rd_addr = r_idx[aca_pkg::CH_W-1:0];
                    n_state = aca_pkg::S_CHECK;
                end else if (r_next == {1'b0, r_nps}) begin
                    if (!r_tune) begin
                        n_status = 1'b1; n_gch = '0;
                        n_state = aca_pkg::S_DONE;
                    end else if (r_spread >= aca_pkg::MAX_SPR) begin
                        n_nps = '0; n_tune = 1'b0; n_merge = 1'b0;
                        n_status = 1'b1; n_gch = '0;
                        n_state = aca_pkg::S_DONE;
                    end else begin
                        n_merge = 1'b1;
                        if (tune_n <= {1'b0, aca_pkg::MAX_SPR}) begin
                            n_nps = r_spread[aca_pkg::CH_W-1:0];
                            n_spread = tune_n[aca_pkg::SPR_W-1:0];
                        end else begin
                            if (head < r_mint) begin
                                n_nps = '0; n_tune = 1'b0; n_merge = 1'b0;
                            end
                            n_spread = aca_pkg::MAX_SPR;
                        end
                        n_old = aca_pkg::sat_add(r_old, r_new);
                        n_new = '0;
                        n_next = {1'b0, n_nps};
                        n_idx = {1'b0, n_nps};
                        n_end = n_spread;
                        // a step that adds nothing ends the search
                        if (n_spread == r_spread) begin
                            n_status = 1'b1; n_gch = '0;
                            n_state = aca_pkg::S_DONE;
                        end
                    end
                end else begin
                    n_end = r_next;
                    n_next = {1'b0, r_nps};
                    n_idx = {1'b0, r_nps};
                end
            end
            aca_pkg::S_CHECK: begin
                if (count < r_max_pending) begin
                    mem_req.wr_en = 1'b1;
                    mem_req.wr_addr = r_idx[aca_pkg::CH_W-1:0];
                    mem_req.wr_data = count + 1'b1;
                    n_next = r_idx + 1'b1;
                    if (r_nps == '0 || r_idx < {1'b0, r_nps}) begin
                        n_old = aca_pkg::sat_add(r_old, aca_pkg::LOAD_W'(1));
                    end else begin
                        n_new = aca_pkg::sat_add(r_new, aca_pkg::LOAD_W'(1));
                    end
                    n_status = 1'b0;
                    n_gch = r_idx[aca_pkg::CH_W-1:0];
                    n_state = aca_pkg::S_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                    n_state = aca_pkg::S_SCAN;
                end
            end
            aca_pkg::S_RMW: begin
                n_state = aca_pkg::S_DONE;
                if (r_op == aca_pkg::OP_RET) begin
                    n_status = 1'b0; n_gch = '0;
                    if (count != '0) begin
                        mem_req.wr_en = 1'b1;
                        mem_req.wr_addr = r_idx[aca_pkg::CH_W-1:0];
                        mem_req.wr_data = count - 1'b1;
                        if (r_nps == '0 || r_idx < {1'b0, r_nps}) begin
                            n_old = old_dec;
                            // old partition drained enough: merge
                            if (r_nps != '0 && r_merge && {1'b0, old_dec} <= new_lim) begin
                                n_merge = 1'b0;
                                n_old = aca_pkg::sat_add(old_dec, r_new);
                                n_new = '0;
                                n_nps = '0;
                            end
                        end else if (r_new != '0) begin
                            n_new = r_new - 1'b1;
                        end
                    end
                end else begin
                    if (count < r_max_pending) begin
                        mem_req.wr_en = 1'b1;
                        mem_req.wr_addr = r_idx[aca_pkg::CH_W-1:0];
                        mem_req.wr_data = count + 1'b1;
                        n_status = 1'b0;
                        n_gch = r_idx[aca_pkg::CH_W-1:0];
                    end else begin
                        n_status = 1'b1; n_gch = '0;
                    end
                end
            end
            aca_pkg::S_DONE: begin
                if (!r_ov || i_out_ready) begin
                    n_ov = 1'b1;
                    n_o_status = r_status;
                    n_o_gch = r_gch;
                    n_o_spr = r_spread;
                    n_o_nps = r_nps;
                    n_o_tune = r_tune;
                    n_state = aca_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = aca_pkg::S_IDLE;
            end
        endcase

        if (i_cfg_valid) begin
            case (i_cfg_index)
                aca_pkg::REG_MAX_PENDING: n_max_pending = i_cfg_data;
                aca_pkg::REG_SPREAD: begin
                    if (cfg_s <= 0) begin
                        cfg_tune = 1'b1;
                        cfg_mag = 8'(-cfg_s);
                    end else begin
                        cfg_tune = 1'b0;
                        n_merge = 1'b0;
                        n_nps = '0;
                        cfg_mag = i_cfg_data;
                    end
                    n_tune = cfg_tune;
                    cfg_ns = (cfg_mag < {1'b0, aca_pkg::MAX_SPR}) ?
                             cfg_mag[aca_pkg::SPR_W-1:0] : aca_pkg::MAX_SPR;
                    if (cfg_mag != '0) begin
                        if (cfg_tune && cfg_ns < r_spread) begin
                            n_merge = 1'b0;
                            n_nps = '0;
                        end
                        n_spread = cfg_ns;
                    end
                end
                aca_pkg::REG_MID_TUNE: n_mid  = i_cfg_data[6:0];
                aca_pkg::REG_ZIP_TUNE: n_zip  = i_cfg_data[6:0];
                aca_pkg::REG_MAX_TUNE: n_mxt  = i_cfg_data[6:0];
                aca_pkg::REG_MIN_TUNE: n_mint = i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= aca_pkg::S_IDLE;
            r_max_pending <= aca_pkg::RST_MAX_PENDING;
            r_mid <= aca_pkg::RST_MID_TUNE;
            r_zip <= aca_pkg::RST_ZIP_TUNE;
            r_mxt <= aca_pkg::RST_MAX_TUNE;
            r_mint <= aca_pkg::RST_MIN_TUNE;
            r_spread <= aca_pkg::SPR_W'(8'(-signed'(aca_pkg::RST_SPREAD_REQ)));
            r_tune <= 1'b1;
            r_next <= '0;
            r_nps <= '0;
            r_old <= '0;
            r_new <= '0;
            r_merge <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_max_pending <= n_max_pending;
            r_mid <= n_mid; r_zip <= n_zip; r_mxt <= n_mxt; r_mint <= n_mint;
            r_spread <= n_spread;
            r_tune <= n_tune;
            r_next <= n_next;
            r_nps <= n_nps;
            r_old <= n_old;
            r_new <= n_new;
            r_merge <= n_merge;
            r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx; r_end <= n_end; r_gch <= n_gch; r_status <= n_status;
        r_op <= n_op;
        r_o_status <= n_o_status; r_o_gch <= n_o_gch; r_o_spr <= n_o_spr;
        r_o_nps <= n_o_nps; r_o_tune <= n_o_tune;
    end

    assign o_in_ready = (r_state == aca_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_ov;
    assign o_status = r_o_status;
    assign o_granted_channel = r_o_gch;
    assign o_spread_now = r_o_spr;
    assign o_partition_start = r_o_nps;
    assign o_auto_tuning = r_o_tune;

    a_check_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == aca_pkg::S_CHECK) |-> (r_idx < aca_pkg::MAX_SPR))
        else $error("scan compare on channel out of range");

    a_check_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == aca_pkg::S_CHECK) |-> ($past(r_state) == aca_pkg::S_SCAN))
        else $error("compare without memory read");

    a_spread_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_spread <= aca_pkg::MAX_SPR) && (r_next <= aca_pkg::MAX_SPR))
        else $error("spread or next channel past channel count");

    a_part_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_nps == '0) || ({1'b0, r_nps} < r_spread))
        else $error("new partition starts outside spread");

endmodule
